// File: rtl/rolling_hash_combine_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for rolling_hash_combine
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_COMBINE_DEFINES_SVH
`define ROLLING_HASH_COMBINE_DEFINES_SVH

`ifndef SYNTH

`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define RHC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define RHC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the rolling hash combine block.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int LENGTH_BITS    = 20;
	localparam int HASH_BITS      = 31;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 31;
	localparam int BIT_IDX_BITS   = $clog2(LENGTH_BITS);
	localparam int STEP_BITS      = $clog2(HASH_BITS);

	localparam logic [HASH_BITS-1:0] RESET_MODULUS = 31'd1921500998;
	localparam logic [HASH_BITS-1:0] RESET_BASE    = 31'd257;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_MODULUS   = 1'b0,
		CFG_HASH_BASE = 1'b1
	} cfg_index_t;

	typedef enum logic [0:0] {
		CMD_CONCAT = 1'b0,
		CMD_REMOVE = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_UNDERFLOW = 2'd1,
		STATUS_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		command_t               command;
		logic [LENGTH_BITS-1:0] left_length;
		logic [HASH_BITS-1:0]   left_hash;
		logic [LENGTH_BITS-1:0] right_length;
		logic [HASH_BITS-1:0]   right_hash;
	} in_t;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] result_length;
		logic [HASH_BITS-1:0]   result_hash;
		status_t                status;
	} out_t;

	typedef struct packed {
		logic                 go;
		logic [HASH_BITS-1:0] a;
		logic [HASH_BITS-1:0] b;
	} mm_req_t;

endpackage

// File: rtl/rhc_modmul.sv
// ----------------------------------------------------------------------------
// rhc_modmul
// Bit-serial modular multiplier: prod = a * b mod m, one bit of b per cycle,
// most significant bit first. The multiplicand a must not exceed m.
// ----------------------------------------------------------------------------
`include "rolling_hash_combine_defines.svh"

module rhc_modmul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rhc_pkg::mm_req_t                    req,
	input  logic [rhc_pkg::HASH_BITS-1:0]       m,
	output logic                                done,
	output logic [rhc_pkg::HASH_BITS-1:0]       prod
);

	logic                            run_q;
	logic                            done_q;
	logic [rhc_pkg::STEP_BITS-1:0]   cnt_q;
	logic [rhc_pkg::HASH_BITS-1:0]   acc_q;
	logic [rhc_pkg::HASH_BITS-1:0]   a_q;
	logic [rhc_pkg::HASH_BITS-1:0]   b_q;

	logic [rhc_pkg::HASH_BITS:0]     dbl;
	logic [rhc_pkg::HASH_BITS:0]     dbl_sub;
	logic [rhc_pkg::HASH_BITS-1:0]   dbl_red;
	logic [rhc_pkg::HASH_BITS:0]     sum;
	logic [rhc_pkg::HASH_BITS:0]     sum_sub;
	logic [rhc_pkg::HASH_BITS-1:0]   sum_red;
	logic [rhc_pkg::HASH_BITS-1:0]   acc_next;

	always_comb begin
		dbl      = {acc_q, 1'b0};
		dbl_sub  = dbl - {1'b0, m};
		dbl_red  = (dbl >= {1'b0, m}) ? dbl_sub[rhc_pkg::HASH_BITS-1:0]
			: dbl[rhc_pkg::HASH_BITS-1:0];
		sum      = {1'b0, dbl_red} + {1'b0, a_q};
		sum_sub  = sum - {1'b0, m};
		sum_red  = (sum >= {1'b0, m}) ? sum_sub[rhc_pkg::HASH_BITS-1:0]
			: sum[rhc_pkg::HASH_BITS-1:0];
		acc_next = b_q[rhc_pkg::HASH_BITS-1] ? sum_red : dbl_red;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= rhc_pkg::STEP_BITS'(rhc_pkg::HASH_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
		end else if (run_q) begin
			acc_q <= acc_next;
			b_q   <= {b_q[rhc_pkg::HASH_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	`RHC_ASSERT_IMP(a_go_when_idle, clk, arst_n, req.go, !run_q)
	`RHC_ASSERT_NXT(a_done_after_last, clk, arst_n, run_q && cnt_q == '0 && !req.go, done_q)
	`RHC_ASSERT_IMP(a_done_stopped, clk, arst_n, done_q, !run_q)

endmodule

// File: rtl/rolling_hash_combine.sv
// ----------------------------------------------------------------------------
// rolling_hash_combine
// Concatenates two polynomial string hashes or removes one as a prefix of the
// other, using a shared bit-serial modular multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// item      start / busy           in_t (command, lengths, hashes)
// result    result_valid strobe    out_t (length, hash, status)
// config    cfg_we                 cfg_index, cfg_data
//
// Every multiplication runs on the shared multiplier. An item needs
// 24 + popcount(e) multiplications, where e is the exponent of the base power,
// so busy stays high while they run after the beat is accepted, and the result
// strobe rises at the same edge at which busy falls. Reset clears the sequencer
// and loads the register defaults. The receiver cannot stall; each result is
// shown for one cycle.
// ----------------------------------------------------------------------------
`include "rolling_hash_combine_defines.svh"

module rolling_hash_combine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  rhc_pkg::in_t                        item,
	output logic                                result_valid,
	output rhc_pkg::out_t                       result,
	input  logic                                cfg_we,
	input  rhc_pkg::cfg_index_t                 cfg_index,
	input  logic [rhc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_BASE,
		ST_RED_LEFT,
		ST_RED_RIGHT,
		ST_POW_SQ,
		ST_POW_MUL,
		ST_FINAL
	} state_t;

	state_t                              state_q;
	logic                                go_q;
	logic [rhc_pkg::HASH_BITS-1:0]       modulus_q;
	logic [rhc_pkg::HASH_BITS-1:0]       hash_base_q;
	rhc_pkg::in_t                        item_q;
	logic [rhc_pkg::LENGTH_BITS-1:0]     exp_q;
	logic [rhc_pkg::LENGTH_BITS-1:0]     len_q;
	rhc_pkg::status_t                    status_q;
	logic [rhc_pkg::BIT_IDX_BITS-1:0]    bit_q;
	logic [rhc_pkg::HASH_BITS-1:0]       base_q;
	logic [rhc_pkg::HASH_BITS-1:0]       ha_q;
	logic [rhc_pkg::HASH_BITS-1:0]       hb_q;
	logic [rhc_pkg::HASH_BITS-1:0]       acc_q;
	rhc_pkg::out_t                       result_q;
	logic                                result_valid_q;

	logic [rhc_pkg::HASH_BITS-1:0]       m_eff;
	logic [rhc_pkg::HASH_BITS-1:0]       one_mod;
	rhc_pkg::mm_req_t                    mm_req;
	logic                                mm_done;
	logic [rhc_pkg::HASH_BITS-1:0]       mm_prod;
	logic                                accept;
	logic [rhc_pkg::LENGTH_BITS:0]       len_sum;
	logic [rhc_pkg::LENGTH_BITS-1:0]     len_diff;
	logic                                len_under;
	logic [rhc_pkg::HASH_BITS:0]         cat_sum;
	logic [rhc_pkg::HASH_BITS:0]         cat_sub;
	logic [rhc_pkg::HASH_BITS:0]         rem_diff;
	logic [rhc_pkg::HASH_BITS:0]         rem_wrap;
	logic [rhc_pkg::HASH_BITS-1:0]       final_hash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= rhc_pkg::RESET_MODULUS;
			hash_base_q <= rhc_pkg::RESET_BASE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rhc_pkg::CFG_MODULUS:   modulus_q   <= cfg_data;
				rhc_pkg::CFG_HASH_BASE: hash_base_q <= cfg_data;
			endcase
		end
	end

	assign m_eff   = (modulus_q < 31'd2) ? 31'd1 : modulus_q;
	assign one_mod = (m_eff == 31'd1) ? 31'd0 : 31'd1;
	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);

	assign len_sum   = {1'b0, item.left_length} + {1'b0, item.right_length};
	assign len_under = item.right_length > item.left_length;
	assign len_diff  = len_under ? '0 : (item.left_length - item.right_length);

	always_comb begin
		mm_req.go = go_q;
		unique case (state_q)
			ST_IDLE: begin
				mm_req.a = '0;
				mm_req.b = '0;
			end
			ST_RED_BASE: begin
				mm_req.a = 31'd1;
				mm_req.b = hash_base_q;
			end
			ST_RED_LEFT: begin
				mm_req.a = 31'd1;
				mm_req.b = item_q.left_hash;
			end
			ST_RED_RIGHT: begin
				mm_req.a = 31'd1;
				mm_req.b = item_q.right_hash;
			end
			ST_POW_SQ: begin
				mm_req.a = acc_q;
				mm_req.b = acc_q;
			end
			ST_POW_MUL: begin
				mm_req.a = base_q;
				mm_req.b = acc_q;
			end
			ST_FINAL: begin
				mm_req.a = acc_q;
				mm_req.b = (item_q.command == rhc_pkg::CMD_CONCAT) ? ha_q : hb_q;
			end
		endcase
	end

	always_comb begin
		cat_sum  = {1'b0, mm_prod} + {1'b0, hb_q};
		cat_sub  = cat_sum - {1'b0, m_eff};
		rem_diff = {1'b0, ha_q} - {1'b0, mm_prod};
		rem_wrap = rem_diff + {1'b0, m_eff};
		if (item_q.command == rhc_pkg::CMD_CONCAT) begin
			final_hash = (cat_sum >= {1'b0, m_eff}) ? cat_sub[rhc_pkg::HASH_BITS-1:0]
				: cat_sum[rhc_pkg::HASH_BITS-1:0];
		end else begin
			final_hash = (ha_q >= mm_prod) ? rem_diff[rhc_pkg::HASH_BITS-1:0]
				: rem_wrap[rhc_pkg::HASH_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			go_q           <= 1'b0;
			result_valid_q <= 1'b0;
			item_q         <= '0;
			exp_q          <= '0;
			len_q          <= '0;
			status_q       <= rhc_pkg::STATUS_OK;
			bit_q          <= '0;
			base_q         <= '0;
			ha_q           <= '0;
			hb_q           <= '0;
			acc_q          <= '0;
			result_q       <= '0;
		end else begin
			go_q           <= 1'b0;
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q  <= item;
						state_q <= ST_RED_BASE;
						go_q    <= 1'b1;
						if (item.command == rhc_pkg::CMD_CONCAT) begin
							exp_q <= item.right_length;
							if (len_sum[rhc_pkg::LENGTH_BITS]) begin
								len_q    <= '1;
								status_q <= rhc_pkg::STATUS_OVERFLOW;
							end else begin
								len_q    <= len_sum[rhc_pkg::LENGTH_BITS-1:0];
								status_q <= rhc_pkg::STATUS_OK;
							end
						end else begin
							exp_q    <= len_diff;
							len_q    <= len_diff;
							status_q <= len_under ? rhc_pkg::STATUS_UNDERFLOW
								: rhc_pkg::STATUS_OK;
						end
					end
				end
				ST_RED_BASE: begin
					if (mm_done) begin
						base_q  <= mm_prod;
						state_q <= ST_RED_LEFT;
						go_q    <= 1'b1;
					end
				end
				ST_RED_LEFT: begin
					if (mm_done) begin
						ha_q    <= mm_prod;
						state_q <= ST_RED_RIGHT;
						go_q    <= 1'b1;
					end
				end
				ST_RED_RIGHT: begin
					if (mm_done) begin
						hb_q    <= mm_prod;
						acc_q   <= one_mod;
						bit_q   <= rhc_pkg::BIT_IDX_BITS'(rhc_pkg::LENGTH_BITS - 1);
						state_q <= ST_POW_SQ;
						go_q    <= 1'b1;
					end
				end
				ST_POW_SQ: begin
					if (mm_done) begin
						acc_q <= mm_prod;
						go_q  <= 1'b1;
						if (exp_q[bit_q]) begin
							state_q <= ST_POW_MUL;
						end else if (bit_q == '0) begin
							state_q <= ST_FINAL;
						end else begin
							bit_q   <= bit_q - 1'b1;
							state_q <= ST_POW_SQ;
						end
					end
				end
				ST_POW_MUL: begin
					if (mm_done) begin
						acc_q <= mm_prod;
						go_q  <= 1'b1;
						if (bit_q == '0) begin
							state_q <= ST_FINAL;
						end else begin
							bit_q   <= bit_q - 1'b1;
							state_q <= ST_POW_SQ;
						end
					end
				end
				ST_FINAL: begin
					if (mm_done) begin
						result_q.result_length <= len_q;
						result_q.result_hash   <= final_hash;
						result_q.status        <= status_q;
						result_valid_q         <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
			endcase
		end
	end

	rhc_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.m      (m_eff),
		.done   (mm_done),
		.prod   (mm_prod)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`RHC_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy)
	`RHC_ASSERT_IMP(a_result_idle, clk, arst_n, result_valid_q, state_q == ST_IDLE)
	`RHC_ASSERT_IMP(a_go_busy, clk, arst_n, go_q, state_q != ST_IDLE)

endmodule

// File: verif/tb_rolling_hash_combine.sv
// ----------------------------------------------------------------------------
// tb_rolling_hash_combine
// Self-checking bench for the rolling hash combiner. A queue of operations is
// driven on the start/busy handshake with random gaps, and every result beat
// is compared field by field with an in-bench model that does concatenation
// and prefix removal by modular square-and-multiply. The modulus and base are
// reprogrammed between phases, covering the extremes and a degenerate modulus.
// ----------------------------------------------------------------------------
module tb_rolling_hash_combine;
	import rhc_pkg::*;

	localparam int LEN_MAX        = 2 ** LENGTH_BITS - 1;
	localparam int TAIL_CYCLES    = 1500;
	localparam int CYCLE_LIMIT    = 5_000_000;
	localparam logic [HASH_BITS-1:0] HASH_ONES = '1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	in_t                      item = '0;
	logic                     result_valid;
	out_t                     result;
	logic                     cfg_we = 1'b0;
	cfg_index_t               cfg_index = CFG_MODULUS;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	in_t                      queued_ops[$];
	out_t                     predicted_results[$];
	logic [HASH_BITS-1:0]     model_modulus = RESET_MODULUS;
	logic [HASH_BITS-1:0]     model_base = RESET_BASE;
	logic [HASH_BITS-1:0]     cur_modulus = RESET_MODULUS;
	logic                     took = 1'b0;
	int unsigned              gap = 0;
	int unsigned              errors = 0;
	int unsigned              cycle_count = 0;

	rolling_hash_combine i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] base_power(logic [63:0] b, logic [LENGTH_BITS-1:0] e,
			logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		for (int i = LENGTH_BITS - 1; i >= 0; i--) begin
			acc = (acc * acc) % m;
			if (e[i]) begin
				acc = (acc * b) % m;
			end
		end
		return acc;
	endfunction

	function automatic out_t combine_hashes(in_t op);
		logic [63:0]            m;
		logic [63:0]            b;
		logic [63:0]            ha;
		logic [63:0]            hb;
		logic [63:0]            sum;
		logic [LENGTH_BITS-1:0] expo;
		out_t                   r;
		m = (model_modulus < 2) ? 64'd1 : 64'(model_modulus);
		b = 64'(model_base) % m;
		ha = 64'(op.left_hash) % m;
		hb = 64'(op.right_hash) % m;
		r.status = STATUS_OK;
		if (op.command == CMD_CONCAT) begin
			sum = 64'(op.left_length) + 64'(op.right_length);
			if (sum > LEN_MAX) begin
				r.result_length = '1;
				r.status = STATUS_OVERFLOW;
			end else begin
				r.result_length = sum[LENGTH_BITS-1:0];
			end
			r.result_hash = HASH_BITS'(((ha * base_power(b, op.right_length, m)) % m + hb) % m);
		end else begin
			if (op.right_length > op.left_length) begin
				expo = '0;
				r.status = STATUS_UNDERFLOW;
			end else begin
				expo = op.left_length - op.right_length;
			end
			r.result_length = expo;
			r.result_hash = HASH_BITS'((ha + m - (base_power(b, expo, m) * hb) % m) % m);
		end
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		out_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODULUS:   model_modulus = cfg_data;
					CFG_HASH_BASE: model_base = cfg_data;
				endcase
			end
			took <= start && !busy;
			if (start && !busy) begin
				predicted_results = {predicted_results, combine_hashes(item)};
			end
			if (result_valid === 1'b1) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %p", $time, result);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					if (result.result_length !== want.result_length) begin
						$display("%0t: result_length expected %0d got %0d", $time,
							want.result_length, result.result_length);
						errors++;
					end
					if (result.result_hash !== want.result_hash) begin
						$display("%0t: result_hash expected %0d got %0d", $time,
							want.result_hash, result.result_hash);
						errors++;
					end
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want.status, result.status);
						errors++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin : driver
		int r;
		if (arst_n && (!start || took)) begin
			if (gap != 0) begin
				start <= 1'b0;
				gap = gap - 1;
			end else if (queued_ops.size() != 0) begin
				item <= queued_ops.pop_front();
				start <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 55) begin
					gap = 0;
				end else if (r < 92) begin
					gap = $urandom_range(1, 8);
				end else begin
					gap = $urandom_range(9, 1500);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic [LENGTH_BITS-1:0] pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return LENGTH_BITS'($urandom_range(0, 40));
		end else if (r < 6) begin
			return LENGTH_BITS'(LEN_MAX - $urandom_range(0, 40));
		end
		return LENGTH_BITS'($urandom_range(0, LEN_MAX));
	endfunction

	function automatic logic [HASH_BITS-1:0] pick_hash();
		if ($urandom_range(0, 3) == 0 || cur_modulus < 2) begin
			return HASH_BITS'($urandom);
		end
		return HASH_BITS'($urandom % cur_modulus);
	endfunction

	task automatic add_op(command_t c, logic [LENGTH_BITS-1:0] la, logic [HASH_BITS-1:0] ha,
			logic [LENGTH_BITS-1:0] lb, logic [HASH_BITS-1:0] hb);
		in_t op;
		op.command = c;
		op.left_length = la;
		op.left_hash = ha;
		op.right_length = lb;
		op.right_hash = hb;
		queued_ops = {queued_ops, op};
	endtask

	task automatic queue_random_ops(int count);
		logic [LENGTH_BITS-1:0] la;
		logic [LENGTH_BITS-1:0] lb;
		for (int n = 0; n < count; n++) begin
			la = pick_length();
			if ($urandom_range(0, 1) == 0) begin
				add_op(CMD_CONCAT, la, pick_hash(), pick_length(), pick_hash());
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					lb = LENGTH_BITS'($urandom_range(0, la));
				end else begin
					lb = pick_length();
				end
				add_op(CMD_REMOVE, la, pick_hash(), lb, pick_hash());
			end
		end
	endtask

	task automatic wait_idle();
		while (queued_ops.size() != 0 || predicted_results.size() != 0 || start || busy) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [HASH_BITS-1:0] m, logic [HASH_BITS-1:0] b, int count);
		wait_idle();
		write_reg(CFG_MODULUS, m);
		write_reg(CFG_HASH_BASE, b);
		cur_modulus = m;
		queue_random_ops(count);
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		add_op(CMD_CONCAT, '0, '0, '0, '0);
		add_op(CMD_CONCAT, '1, HASH_ONES, '1, HASH_ONES);
		add_op(CMD_CONCAT, '1, 31'd12345, 20'd1, 31'd678);
		add_op(CMD_CONCAT, '1, 31'd99, '0, 31'd7);
		add_op(CMD_CONCAT, 20'h80000, 31'd1, 20'h7FFFF, 31'd2);
		add_op(CMD_CONCAT, 20'hAAAAA, 31'h2AAAAAAA, 20'h55555, 31'h55555555);
		add_op(CMD_CONCAT, 20'd3, RESET_MODULUS, 20'd4, RESET_MODULUS - 31'd1);
		add_op(CMD_CONCAT, 20'd0, 31'd42, 20'd1, 31'd0);
		add_op(CMD_REMOVE, '1, HASH_ONES, '1, HASH_ONES);
		add_op(CMD_REMOVE, 20'd5, 31'd1000, 20'd6, 31'd3);
		add_op(CMD_REMOVE, '0, 31'd17, '1, 31'd19);
		add_op(CMD_REMOVE, '1, HASH_ONES, '0, HASH_ONES);
		add_op(CMD_REMOVE, 20'd10, 31'd555, 20'd3, 31'd5);
		add_op(CMD_REMOVE, 20'h55555, 31'h55555555, 20'h2AAAA, 31'h2AAAAAAA);
		add_op(CMD_REMOVE, 20'd7, RESET_MODULUS, 20'd2, RESET_MODULUS);
		add_op(CMD_REMOVE, '0, '0, '0, '0);
		queue_random_ops(70);

		run_phase(31'h7FFFFFFF, 31'h7FFFFFFF, 50);
		run_phase(31'd2, 31'd3, 30);
		run_phase(31'd0, 31'd5, 20);
		run_phase(31'd1, 31'h7FFFFFFF, 20);
		run_phase(31'd1000003, 31'h7FFFFFFE, 50);
		run_phase(31'd65537, 31'd0, 40);
		for (int p = 0; p < 4; p++) begin
			run_phase(HASH_BITS'($urandom_range(2, 32'h7FFFFFFF)),
				($urandom_range(0, 1) == 0) ? HASH_BITS'($urandom) :
				HASH_BITS'($urandom_range(2, 300)), 40);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_modmul.sv
rtl/rolling_hash_combine.sv
verif/tb_rolling_hash_combine.sv
